FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define POGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define POGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pogb_pkg.sv
// ----------------------------------------------------------------------------
// pogb_pkg
// Constants, codes and types of the occupancy grid binner.
// ----------------------------------------------------------------------------
`default_nettype none

package pogb_pkg;

	localparam int GRID_SIDE   = 1024;
	localparam int WORD_CELLS  = 64;

	localparam int ROW_W       = $clog2(GRID_SIDE);
	localparam int COL_W       = $clog2(GRID_SIDE);
	localparam int BIT_W       = $clog2(WORD_CELLS);
	localparam int TOTAL_WORDS = GRID_SIDE * GRID_SIDE / WORD_CELLS;
	localparam int ADDR_W      = $clog2(TOTAL_WORDS);

	localparam int MM_W        = 17;
	localparam int CELL_W      = 8;
	localparam int CLOUD_W     = 10;
	localparam int IDX_W       = 14;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 21;
	localparam int OUT_WORD_W  = 64;

	localparam int CELL_SCALE  = 10;
	localparam int D_W         = CELL_W + 4;
	localparam int DEN_W       = D_W + 1;
	localparam int NUM_W       = MM_W + 1;
	localparam int STEP_W      = $clog2(NUM_W);

	localparam int POP_DIGIT   = 4;
	localparam int POP_STEPS   = WORD_CELLS / POP_DIGIT;
	localparam int POPC_W      = $clog2(POP_STEPS);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 4;
	localparam int REG_LSB     = 2;
	localparam int REG_IDX_W   = PADDR_W - REG_LSB;

	localparam logic signed [MM_W-1:0] HEIGHT_RESET = 17'sd1000;
	localparam logic [CELL_W-1:0]      CELL_RESET   = 8'd8;
	localparam logic [CLOUD_W-1:0]     CLOUDS_RESET = 10'd100;

	typedef enum logic [OP_W-1:0] {
		OP_POINT = 2'd0,
		OP_CLOUD = 2'd1,
		OP_READ  = 2'd2,
		OP_NULL  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED = 3'd0,
		ST_HIGH   = 3'd1,
		ST_OUT    = 3'd2,
		ST_CLOUD  = 3'd3,
		ST_FRAME  = 3'd4,
		ST_READ   = 3'd5
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEIGHT = 2'd0,
		REG_CELL   = 2'd1,
		REG_CLOUDS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_RD,
		S_UPD,
		S_POP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [MM_W-1:0] height_limit;
		logic [CELL_W-1:0]      cell_size;
		logic [CLOUD_W-1:0]     clouds;
	} cfg_t;

endpackage

`default_nettype wire

FILE: sv/point_occupancy_grid_binner.sv
// ----------------------------------------------------------------------------
// point_occupancy_grid_binner
// Bins range-sensor points below a height limit into a 1024 x 1024 bit grid,
// counts occupied cells and point clouds, and reads the grid out as 64-cell words.
// ----------------------------------------------------------------------------
// After reset the block clears the grid memory one word per cycle, all 16384
// words, and holds item_stall high until that is done; register writes are
// taken throughout. One item is worked on at a time and each gives one result.
// A binned point passes through the two bit-serial dividers that form the row
// and column one quotient bit per cycle, followed by a read and a
// read-modify-write of the grid memory. A grid read is the memory read, a
// write that clears the word, and the count update that walks the word four
// bits per cycle. A cloud end, a point at or above the height limit, an
// out-of-range read or a null read goes straight to the result, and a point
// outside the grid goes to the result once the division ends.
// The result register lets the next item transfer while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module point_occupancy_grid_binner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pogb_pkg::PADDR_W-1:0]        paddr,
	input  logic [pogb_pkg::DATA_W-1:0]         pwdata,
	output logic [pogb_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [pogb_pkg::OP_W-1:0]           opcode,
	input  logic signed [pogb_pkg::MM_W-1:0]    point_x_mm,
	input  logic signed [pogb_pkg::MM_W-1:0]    point_y_mm,
	input  logic signed [pogb_pkg::MM_W-1:0]    point_z_mm,
	input  logic [pogb_pkg::IDX_W-1:0]          word_index,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [pogb_pkg::STATUS_W-1:0]       status,
	output logic                                frame_ready,
	output logic [pogb_pkg::COUNT_W-1:0]        occupied_count,
	output logic [pogb_pkg::OUT_WORD_W-1:0]     cell_word,
	output logic                                last_word
);
	import pogb_pkg::*;

	localparam logic [NUM_W-1:0] HALF = NUM_W'(GRID_SIDE / 2);

	cfg_t   cfg;
	state_t state_q, state_d;

	logic                  item_acc;
	logic                  out_free;
	opcode_t               op_in;
	logic                  z_high;
	logic                  cloud_full;
	logic                  idx_ok;
	logic                  idx_last;
	logic                  div_start;

	logic [CELL_W-1:0]     cell_eff;
	logic [D_W-1:0]        dval;
	logic [DEN_W-1:0]      denom;
	logic [MM_W-1:0]       ax, ay;
	logic [NUM_W-1:0]      numer_x, numer_y;
	logic [NUM_W-1:0]      quot_x, quot_y;
	logic                  done_x, done_y;
	logic                  div_done;
	logic                  x_ok, y_ok;
	logic [COL_W-1:0]      col;
	logic [ROW_W-1:0]      row;
	logic [ROW_W+COL_W-1:0] cell_pos;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [WORD_CELLS-1:0] ram_wdata;
	logic [WORD_CELLS-1:0] ram_rdata;
	logic                  bit_set;
	logic [WORD_CELLS-1:0] bit_mask;
	logic [2:0]            pop_digit;

	opcode_t               op_q;
	logic                  neg_x_q, neg_y_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BIT_W-1:0]      bit_q;
	status_t               res_status_q;
	logic [OUT_WORD_W-1:0] res_word_q;
	logic                  res_last_q;
	logic [WORD_CELLS-1:0] pop_q;
	logic [POPC_W-1:0]     pop_cnt_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [CLOUD_W-1:0]    cloud_q;
	logic                  ready_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  result_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  frame_ready_q;
	logic [COUNT_W-1:0]    occupied_count_q;
	logic [OUT_WORD_W-1:0] cell_word_q;
	logic                  last_word_q;

	pogb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign op_in      = opcode_t'(opcode);
	assign z_high     = $signed(point_z_mm) >= $signed(cfg.height_limit);
	assign cloud_full = cloud_q >= cfg.clouds;
	assign idx_ok     = 32'(word_index) < TOTAL_WORDS;
	assign idx_last   = 32'(word_index) == (TOTAL_WORDS - 1);
	assign div_start  = item_acc && (op_in == OP_POINT) && !z_high;

	assign cell_eff = (cfg.cell_size == '0) ? CELL_W'(1) : cfg.cell_size;
	assign dval     = D_W'(cell_eff) * D_W'(CELL_SCALE);
	assign denom    = {dval, 1'b0};
	assign ax       = point_x_mm[MM_W-1] ? (~point_x_mm + MM_W'(1)) : point_x_mm;
	assign ay       = point_y_mm[MM_W-1] ? (~point_y_mm + MM_W'(1)) : point_y_mm;
	assign numer_x  = {ax, 1'b0} + NUM_W'(dval);
	assign numer_y  = {ay, 1'b0} + NUM_W'(dval);

	pogb_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer_x),
		.denom  (denom),
		.quot   (quot_x),
		.done   (done_x)
	);

	pogb_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer_y),
		.denom  (denom),
		.quot   (quot_y),
		.done   (done_y)
	);

	assign div_done = done_x && done_y;
	assign x_ok     = neg_x_q ? (quot_x <= HALF) : (quot_x < HALF);
	assign y_ok     = neg_y_q ? (quot_y <= HALF) : (quot_y < HALF);
	assign col      = COL_W'(neg_x_q ? (HALF - quot_x) : (HALF + quot_x));
	assign row      = ROW_W'(neg_y_q ? (HALF - quot_y) : (HALF + quot_y));
	assign cell_pos = {row, col};

	pogb_ram #(
		.W     (WORD_CELLS),
		.DEPTH (TOTAL_WORDS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign bit_set  = ram_rdata[bit_q];
	assign bit_mask = WORD_CELLS'(1) << bit_q;

	always_comb begin
		pop_digit = '0;
		for (int i = 0; i < POP_DIGIT; i++) begin
			pop_digit = pop_digit + 3'(pop_q[i]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_addr_q == ADDR_W'(TOTAL_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_acc) begin
					case (op_in)
						OP_POINT: state_d = z_high ? S_DONE : S_DIV;
						OP_READ:  state_d = idx_ok ? S_RD : S_DONE;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = (x_ok && y_ok) ? S_RD : S_DONE;
				end
			end
			S_RD: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				state_d = (op_q == OP_READ) ? S_POP : S_DONE;
			end
			S_POP: begin
				if (pop_cnt_q == POPC_W'(POP_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = addr_q;
		ram_wdata  = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
			end
			S_IDLE: begin
				item_stall = 1'b0;
			end
			S_UPD: begin
				if (op_q == OP_READ) begin
					ram_we = 1'b1;
				end else if (!bit_set) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | bit_mask;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_addr_q     <= '0;
			cloud_q        <= '0;
			ready_q        <= 1'b0;
			count_q        <= '0;
			pop_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (item_acc && (op_in == OP_CLOUD)) begin
				if (cloud_full) begin
					ready_q <= 1'b1;
					cloud_q <= '0;
				end else begin
					cloud_q <= cloud_q + CLOUD_W'(1);
				end
			end
			if (state_q == S_UPD) begin
				if (op_q == OP_READ) begin
					if (res_last_q) begin
						ready_q <= 1'b0;
					end
				end else if (!bit_set && (count_q != COUNT_MAX)) begin
					count_q <= count_q + COUNT_W'(1);
				end
				pop_cnt_q <= '0;
			end
			if (state_q == S_POP) begin
				pop_cnt_q <= pop_cnt_q + POPC_W'(1);
				count_q   <= (count_q > COUNT_W'(pop_digit)) ?
				             (count_q - COUNT_W'(pop_digit)) : '0;
			end
			if ((state_q == S_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q       <= op_in;
			neg_x_q    <= point_x_mm[MM_W-1];
			neg_y_q    <= point_y_mm[MM_W-1];
			addr_q     <= ADDR_W'(word_index);
			res_word_q <= '0;
			res_last_q <= (op_in == OP_READ) && idx_ok && idx_last;
			case (op_in)
				OP_POINT: res_status_q <= z_high ? ST_HIGH : ST_STORED;
				OP_CLOUD: res_status_q <= cloud_full ? ST_FRAME : ST_CLOUD;
				default:  res_status_q <= ST_READ;
			endcase
		end
		if ((state_q == S_DIV) && div_done) begin
			if (!(x_ok && y_ok)) begin
				res_status_q <= ST_OUT;
			end
			addr_q <= ADDR_W'(cell_pos >> BIT_W);
			bit_q  <= col[BIT_W-1:0];
		end
		if ((state_q == S_UPD) && (op_q == OP_READ)) begin
			res_word_q <= OUT_WORD_W'(ram_rdata);
			pop_q      <= ram_rdata;
		end
		if (state_q == S_POP) begin
			pop_q <= pop_q >> POP_DIGIT;
		end
		if ((state_q == S_DONE) && out_free) begin
			status_q         <= res_status_q;
			frame_ready_q    <= ready_q;
			occupied_count_q <= count_q;
			cell_word_q      <= res_word_q;
			last_word_q      <= res_last_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign frame_ready    = frame_ready_q;
	assign occupied_count = occupied_count_q;
	assign cell_word      = cell_word_q;
	assign last_word      = last_word_q;

endmodule

`default_nettype wire

FILE: sv/pogb_ram.sv
// ----------------------------------------------------------------------------
// pogb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pogb_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/pogb_div.sv
// ----------------------------------------------------------------------------
// pogb_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pogb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pogb_pkg::NUM_W-1:0] numer,
	input  logic [pogb_pkg::DEN_W-1:0] denom,
	output logic [pogb_pkg::NUM_W-1:0] quot,
	output logic                       done
);
	import pogb_pkg::*;

	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= numer;
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/pogb_cfg.sv
// ----------------------------------------------------------------------------
// pogb_cfg
// APB register file for height limit, cell size and clouds per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pogb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pogb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pogb_pkg::DATA_W-1:0]   pwdata,
	output logic [pogb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pogb_pkg::cfg_t                cfg
);
	import pogb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_LSB]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_limit <= HEIGHT_RESET;
			cfg_q.cell_size    <= CELL_RESET;
			cfg_q.clouds       <= CLOUDS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEIGHT: begin
					cfg_q.height_limit <= $signed(pwdata[MM_W-1:0]);
				end
				REG_CELL: begin
					cfg_q.cell_size <= pwdata[CELL_W-1:0];
				end
				REG_CLOUDS: begin
					cfg_q.clouds <= pwdata[CLOUD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEIGHT: prdata = DATA_W'($signed(cfg_q.height_limit));
			REG_CELL:   prdata = DATA_W'(cfg_q.cell_size);
			REG_CLOUDS: prdata = DATA_W'(cfg_q.clouds);
			default:    prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

FILE: sv/pogb_chk.sv
// ----------------------------------------------------------------------------
// pogb_chk
// Port-level checks on the result channel of the occupancy grid binner.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pogb_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [pogb_pkg::STATUS_W-1:0]   status,
	input  logic                            frame_ready,
	input  logic [pogb_pkg::OUT_WORD_W-1:0] cell_word,
	input  logic                            last_word
);
	import pogb_pkg::*;

	`POGB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(cell_word), "stalled result changed")
	`POGB_ASSERT(a_word_only_on_read, (result_valid && (status != ST_READ)) |-> ((cell_word == '0) && !last_word), "word data on a non-read result")
	`POGB_ASSERT(a_last_clears_frame, (result_valid && last_word) |-> ((status == ST_READ) && !frame_ready), "final word read left frame ready")
	`POGB_ASSERT(a_frame_sets_ready, (result_valid && (status == ST_FRAME)) |-> frame_ready, "frame result without frame ready")

endmodule

bind point_occupancy_grid_binner pogb_chk u_pogb_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.frame_ready  (frame_ready),
	.cell_word    (cell_word),
	.last_word    (last_word)
);

`default_nettype wire
